// ----- rtl/core/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Shared widths, status codes and cell link types for the ack RTT tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

    // Field widths
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 64;
    localparam int AVG_W    = 40;
    localparam int IV_W     = 32;
    localparam int WEIGHT_W = 16;
    localparam int STATUS_W = 3;

    // Defaults
    localparam int                    TABLE_DEPTH_DEF = 16;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET    = 16'd8192;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd4;

    // EWMA unit request tags
    localparam logic TAG_ACK  = 1'b0;
    localparam logic TAG_SEND = 1'b1;

    // Controls broadcast to every cell
    typedef struct packed {
        logic cmp;      // compare pass: latch match flags
        logic sel;      // select pass: write or purge
        logic is_ack;
        logic dup_any;  // some cell already holds the sent seq
    } t_cell_ctl;

    // Key broadcast to every cell
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  want;   // seq - 1 for ack lookup
        logic [TIME_W-1:0] time_us;
    } t_cell_key;

    // Link handed from one cell to its neighbor
    typedef struct packed {
        logic              free_seen;
        logic              hit_any;
        logic              dup_any;
        logic [TIME_W-1:0] hit_time;
    } t_chain;

endpackage

`default_nettype wire

// ----- rtl/core/art_cell.sv -----
// ----------------------------------------------------------------------------
// art_cell
// One table entry: holds seq and send time, compares against the broadcast
// key and passes free, hit and duplicate information to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module art_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire art_pkg::t_cell_ctl i_ctl,
    input  wire art_pkg::t_cell_key i_key,
    input  wire art_pkg::t_chain    i_chain,
    output art_pkg::t_chain       o_chain
);

    logic                          r_valid;
    logic [art_pkg::SEQ_W-1:0]     r_seq;
    logic [art_pkg::TIME_W-1:0]    r_time;
    logic                          r_dup;
    logic                          r_hit;
    logic                          r_below;
    logic                          w_take;

    // Take the slot if empty and no earlier cell is empty
    assign w_take = !r_valid && !i_chain.free_seen;

    // Hand results on to the neighbor
    assign o_chain.free_seen = i_chain.free_seen || !r_valid;
    assign o_chain.hit_any   = i_chain.hit_any || r_hit;
    assign o_chain.dup_any   = i_chain.dup_any || r_dup;
    assign o_chain.hit_time  = i_chain.hit_time | (r_hit ? r_time : '0);

    // Latch match flags on the compare pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup   <= 1'b0;
            r_hit   <= 1'b0;
            r_below <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_dup   <= r_valid && (r_seq == i_key.seq);
            r_hit   <= r_valid && (r_seq == i_key.want);
            r_below <= r_valid && (r_seq < i_key.seq);
        end
    end

    // Store a new send or purge on an ack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.sel) begin
            if (i_ctl.is_ack) begin
                if (r_below) begin
                    r_valid <= 1'b0;
                end
            end else if (!i_ctl.dup_any && w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.sel && !i_ctl.is_ack && !i_ctl.dup_any && w_take) begin
            r_seq  <= i_key.seq;
            r_time <= i_key.time_us;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/art_ewma.sv -----
// ----------------------------------------------------------------------------
// art_ewma
// Three-stage EWMA update: new = ((old << 16) + w * (sample - old) + 0.5)
// >> 16, with sample the interval in Q32.8. Requests carry a tag through.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ewma (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire                               i_tag,
    input  wire [art_pkg::AVG_W-1:0]          i_old,
    input  wire [art_pkg::IV_W-1:0]           i_iv,
    input  wire [art_pkg::WEIGHT_W-1:0]       i_weight,
    output logic                              o_valid,
    output logic                              o_tag,
    output logic [art_pkg::AVG_W-1:0]         o_avg
);

    localparam int DIFF_W = art_pkg::AVG_W + 1;
    localparam int PROD_W = DIFF_W + art_pkg::WEIGHT_W + 1;
    localparam int ACC_W  = PROD_W + 1;

    logic [1:0]                      r_vld;
    logic [1:0]                      r_tag;
    logic signed [DIFF_W-1:0]        r_diff;
    logic signed [PROD_W-1:0]        r_prod;
    logic [art_pkg::AVG_W-1:0]       r_old1;
    logic [art_pkg::AVG_W-1:0]       r_old2;
    logic signed [art_pkg::WEIGHT_W:0] w_wt;
    logic signed [ACC_W-1:0]         w_acc;

    assign w_wt = $signed({1'b0, i_weight});

    // Round half up and drop the fraction
    assign w_acc = $signed({3'b000, r_old2, 16'h0000})
                 + $signed({r_prod[PROD_W-1], r_prod})
                 + $signed(ACC_W'(32768));

    // Valid and tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[0], i_valid};
            o_valid <= r_vld[1];
        end
    end

    // Datapath stages: difference, product, sum
    always_ff @(posedge i_clk) begin
        r_tag  <= {r_tag[0], i_tag};
        o_tag  <= r_tag[1];
        r_diff <= $signed({1'b0, i_iv, 8'h00}) - $signed({1'b0, i_old});
        r_old1 <= i_old;
        r_prod <= PROD_W'(w_wt) * PROD_W'(r_diff);
        r_old2 <= r_old1;
        o_avg  <= w_acc[art_pkg::AVG_W+15:16];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ack_rtt_ewma_tracker.sv -----
// ----------------------------------------------------------------------------
// ack_rtt_ewma_tracker
// Send/ack event tracker: stores send times in a row of cells, reports RTT
// on a matching ack and keeps EWMAs of ack and send intervals.
// A send passes the cell row's compare and select passes and then gives its result
// strobe; an ack takes the same passes plus two trips through the 3-stage EWMA
// unit. The next item can be taken in the strobe cycle, and none while busy, so
// each item finishes before the next is accepted.
// The result receiver cannot stall; each result shows for one cycle.
// Synchronous reset empties the table, zeroes averages and times and sets
// the weight to 0.125.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_rtt_ewma_tracker #(
    parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_opcode,
    input  wire [art_pkg::SEQ_W-1:0]           i_seq_num,
    input  wire [art_pkg::TIME_W-1:0]          i_time_us,
    input  wire                                i_cfg_we,
    input  wire [art_pkg::WEIGHT_W-1:0]        i_cfg_wdata,
    output logic                               o_done,
    output logic [art_pkg::STATUS_W-1:0]       o_status,
    output logic [art_pkg::AVG_W-1:0]          o_ack_avg,
    output logic [art_pkg::AVG_W-1:0]          o_send_avg,
    output logic [art_pkg::IV_W-1:0]           o_rtt_us,
    output logic [art_pkg::TIME_W-1:0]         o_matched_send_time
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_EW1  = 3'd3;
    localparam logic [2:0] S_EW2  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [art_pkg::WEIGHT_W-1:0]      r_weight;

    logic                              r_op;
    logic [art_pkg::SEQ_W-1:0]         r_seq;
    logic [art_pkg::TIME_W-1:0]        r_time;

    logic [art_pkg::IV_W-1:0]          r_ack_iv;
    logic [art_pkg::IV_W-1:0]          r_snd_iv;
    logic [art_pkg::IV_W-1:0]          r_rtt;
    logic                              r_hit;
    logic [art_pkg::TIME_W-1:0]        r_hit_time;
    logic                              r_dup;
    logic                              r_full;

    logic [art_pkg::TIME_W-1:0]        r_prev_ack;
    logic [art_pkg::TIME_W-1:0]        r_prev_send;
    logic [art_pkg::TIME_W-1:0]        r_last_send;
    logic                              r_seen_first;
    logic [art_pkg::AVG_W-1:0]         r_ack_ewma;
    logic [art_pkg::AVG_W-1:0]         r_send_ewma;

    art_pkg::t_cell_ctl                w_ctl;
    art_pkg::t_cell_key                w_key;
    art_pkg::t_chain                   w_chain [TABLE_DEPTH+1];

    logic                              w_ew_valid;
    logic                              w_ew_tag;
    logic [art_pkg::AVG_W-1:0]         w_ew_old;
    logic [art_pkg::IV_W-1:0]          w_ew_iv;
    logic                              w_ew_done;
    logic                              w_ew_done_tag;
    logic [art_pkg::AVG_W-1:0]         w_ew_avg;

    logic [art_pkg::STATUS_W-1:0]      w_status;

    // Interval later - earlier, clamped to 0..2^32-1
    function automatic logic [art_pkg::IV_W-1:0] f_clamp(
        input logic [art_pkg::TIME_W-1:0] later,
        input logic [art_pkg::TIME_W-1:0] earlier
    );
        logic [art_pkg::TIME_W:0] d;
        d = {1'b0, later} - {1'b0, earlier};
        if (d[art_pkg::TIME_W]) begin
            return '0;
        end else if (|d[art_pkg::TIME_W-1:art_pkg::IV_W]) begin
            return '1;
        end else begin
            return d[art_pkg::IV_W-1:0];
        end
    endfunction

    assign busy = (r_state != S_IDLE);

    // Broadcast to the cell row
    assign w_ctl.cmp     = (r_state == S_CMP);
    assign w_ctl.sel     = (r_state == S_SEL);
    assign w_ctl.is_ack  = r_op;
    assign w_ctl.dup_any = w_chain[TABLE_DEPTH].dup_any;
    assign w_key.seq     = r_seq;
    assign w_key.want    = r_seq - 32'd1;
    assign w_key.time_us = r_time;
    assign w_chain[0]    = '0;

    // Row of table cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        art_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (w_key),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    // Feed the shared EWMA unit: ack average first, then send average
    assign w_ew_valid = (r_state == S_EW1) || (r_state == S_EW2);
    assign w_ew_tag   = (r_state == S_EW2) ? art_pkg::TAG_SEND : art_pkg::TAG_ACK;
    assign w_ew_old   = (r_state == S_EW2) ? r_send_ewma : r_ack_ewma;
    assign w_ew_iv    = (r_state == S_EW2) ? r_snd_iv : r_ack_iv;

    art_ewma u_ewma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ew_valid),
        .i_tag    (w_ew_tag),
        .i_old    (w_ew_old),
        .i_iv     (w_ew_iv),
        .i_weight (r_weight),
        .o_valid  (w_ew_done),
        .o_tag    (w_ew_done_tag),
        .o_avg    (w_ew_avg)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_CMP;
            S_CMP:  n_state = S_SEL;
            S_SEL:  n_state = r_op ? S_EW1 : S_OUT;
            S_EW1:  n_state = S_EW2;
            S_EW2:  n_state = S_WAIT;
            S_WAIT: if (w_ew_done && (w_ew_done_tag == art_pkg::TAG_SEND)) n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Result status
    always_comb begin
        priority if (r_op) begin
            w_status = r_hit ? art_pkg::ST_MATCHED : art_pkg::ST_UNMATCHED;
        end else if (r_dup) begin
            w_status = art_pkg::ST_DUPLICATE;
        end else if (r_full) begin
            w_status = art_pkg::ST_FULL;
        end else begin
            w_status = art_pkg::ST_STORED;
        end
    end

    // Control state, weight register and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_weight     <= art_pkg::WEIGHT_RESET;
            r_prev_ack   <= '0;
            r_prev_send  <= '0;
            r_last_send  <= '0;
            r_seen_first <= 1'b0;
            r_ack_ewma   <= '0;
            r_send_ewma  <= '0;
            o_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= (r_state == S_OUT);
            if (i_cfg_we) begin
                r_weight <= i_cfg_wdata;
            end
            // Record this ack's time after the interval is taken
            if ((r_state == S_SEL) && r_op) begin
                r_prev_ack <= r_time;
            end
            // Move send times to the matched entry
            if ((r_state == S_EW1) && r_hit) begin
                r_prev_send <= r_hit_time;
                r_last_send <= r_hit_time;
            end
            // Commit averages once a prior ack exists, the send average only on a hit
            if (w_ew_done && r_seen_first) begin
                if (w_ew_done_tag == art_pkg::TAG_ACK) begin
                    r_ack_ewma <= w_ew_avg;
                end else if (r_hit) begin
                    r_send_ewma <= w_ew_avg;
                end
            end
            if ((r_state == S_OUT) && r_op) begin
                r_seen_first <= 1'b1;
            end
        end
    end

    // Item payload and intermediate values
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_op   <= i_opcode;
            r_seq  <= i_seq_num;
            r_time <= i_time_us;
        end
        if (r_state == S_CMP) begin
            r_ack_iv <= f_clamp(r_time, r_prev_ack);
        end
        if (r_state == S_SEL) begin
            r_hit      <= w_chain[TABLE_DEPTH].hit_any;
            r_hit_time <= w_chain[TABLE_DEPTH].hit_time;
            r_dup      <= w_chain[TABLE_DEPTH].dup_any;
            r_full     <= !w_chain[TABLE_DEPTH].free_seen;
        end
        if (r_state == S_EW1) begin
            r_snd_iv <= f_clamp(r_hit_time, r_prev_send);
            r_rtt    <= r_hit ? f_clamp(r_time, r_hit_time) : '0;
        end
        if (r_state == S_OUT) begin
            o_status            <= w_status;
            o_ack_avg           <= r_ack_ewma;
            o_send_avg          <= r_send_ewma;
            o_rtt_us            <= r_op ? r_rtt : '0;
            o_matched_send_time <= r_last_send;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/art_checker.sv -----
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks on the tracker's item handshake and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module art_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    input  wire                                busy,
    input  wire                                i_opcode,
    input  wire                                o_done,
    input  wire [art_pkg::STATUS_W-1:0]        o_status,
    input  wire [art_pkg::IV_W-1:0]            o_rtt_us
);

    // Accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A result shows only when the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // A send item's result strobe follows its compare, select and output states
    a_send_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_opcode) |-> ##4 o_done)
        else $error("send result missing after four cycles");

    // Status comes from the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == art_pkg::ST_STORED || o_status == art_pkg::ST_DUPLICATE ||
                    o_status == art_pkg::ST_FULL || o_status == art_pkg::ST_MATCHED ||
                    o_status == art_pkg::ST_UNMATCHED))
        else $error("undefined status code");

    // RTT is zero unless the ack matched
    a_rtt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != art_pkg::ST_MATCHED)) |-> (o_rtt_us == '0))
        else $error("nonzero RTT on unmatched result");

endmodule

bind ack_rtt_ewma_tracker art_checker u_art_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_done   (o_done),
    .o_status (o_status),
    .o_rtt_us (o_rtt_us)
);

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ack RTT tracker against a cycle-free predictor of its send table,
// RTT report and the two interval EWMAs. A directed opener hits the table and
// timestamp corners. It is followed by random send/ack flows under several
// weights, with random idle bursts on the command side.
// ----------------------------------------------------------------------------
module testbench;
    import art_pkg::*;

    localparam int              DEPTH       = TABLE_DEPTH_DEF;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              PHASES      = 6;
    localparam int              PHASE_ITEMS = 67;
    localparam int              DRAIN_WAIT  = 12;
    localparam logic            OP_SEND     = 1'b0;
    localparam logic            OP_ACK      = 1'b1;
    localparam logic [SEQ_W-1:0]  SEQ_TOP   = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] TIME_TOP  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit [STATUS_W-1:0] status;
        bit [AVG_W-1:0]    ack_avg;
        bit [AVG_W-1:0]    send_avg;
        bit [IV_W-1:0]     rtt_us;
        bit [TIME_W-1:0]   send_us;
    } rtt_report_t;

    // Tracks the send table and both averages; holds the reports still owed
    class rtt_ewma_board;
        bit [WEIGHT_W-1:0] weight;
        bit                held     [DEPTH];
        bit [SEQ_W-1:0]    held_seq [DEPTH];
        bit [TIME_W-1:0]   held_us  [DEPTH];
        bit [TIME_W-1:0]   last_ack_us;
        bit [TIME_W-1:0]   prev_match_us;
        bit [TIME_W-1:0]   match_us;
        bit                acked_once;
        bit [AVG_W-1:0]    ack_avg;
        bit [AVG_W-1:0]    send_avg;
        rtt_report_t       due_reports [$];
        int unsigned       errors;
        int unsigned       tally [5];

        function new();
            weight = WEIGHT_RESET;
        endfunction

        // Interval clamped to 0..2^32-1, backwards time gives 0
        function bit [IV_W-1:0] gap_us(bit [TIME_W-1:0] later, bit [TIME_W-1:0] earlier);
            bit [TIME_W-1:0] d;
            if (later < earlier)
                return '0;
            d = later - earlier;
            return (d > 64'hFFFF_FFFF) ? '1 : d[IV_W-1:0];
        endfunction

        // Weighted blend of old average and new Q32.8 sample, rounded half up
        function bit [AVG_W-1:0] smooth(bit [AVG_W-1:0] old, bit [IV_W-1:0] gap);
            bit [63:0] acc;
            acc = (64'd65536 - 64'(weight)) * 64'(old)
                + 64'(weight) * {24'd0, gap, 8'd0} + 64'd32768;
            return acc[16 +: AVG_W];
        endfunction

        function void note_event(bit op, bit [SEQ_W-1:0] seq, bit [TIME_W-1:0] t_us);
            rtt_report_t    r;
            int             slot;
            bit             dup;
            bit [SEQ_W-1:0] want;
            slot     = -1;
            dup      = 1'b0;
            r.rtt_us = '0;
            if (op == OP_SEND) begin
                // find a duplicate and the lowest free entry
                foreach (held[i]) begin
                    if (held[i]) begin
                        if (held_seq[i] == seq)
                            dup = 1'b1;
                    end else if (slot < 0) begin
                        slot = i;
                    end
                end
                if (dup) begin
                    r.status = ST_DUPLICATE;
                end else if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    held[slot]     = 1'b1;
                    held_seq[slot] = seq;
                    held_us[slot]  = t_us;
                    r.status       = ST_STORED;
                end
            end else begin
                if (acked_once)
                    ack_avg = smooth(ack_avg, gap_us(t_us, last_ack_us));
                last_ack_us = t_us;
                // look up seq-1, wrapping at zero
                want = seq - 1'b1;
                foreach (held[i]) begin
                    if (slot < 0 && held[i] && held_seq[i] == want)
                        slot = i;
                end
                if (slot >= 0) begin
                    match_us = held_us[slot];
                    if (acked_once)
                        send_avg = smooth(send_avg, gap_us(match_us, prev_match_us));
                    prev_match_us = match_us;
                    r.rtt_us      = gap_us(t_us, match_us);
                    r.status      = ST_MATCHED;
                end else begin
                    r.status = ST_UNMATCHED;
                end
                // purge everything below the acked seq
                foreach (held[i]) begin
                    if (held[i] && held_seq[i] < seq)
                        held[i] = 1'b0;
                end
                acked_once = 1'b1;
            end
            r.ack_avg  = ack_avg;
            r.send_avg = send_avg;
            r.send_us  = match_us;
            tally[r.status]++;
            due_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_report(logic [STATUS_W-1:0] status, logic [AVG_W-1:0] ack_q,
                                   logic [AVG_W-1:0] send_q, logic [IV_W-1:0] rtt_q,
                                   logic [TIME_W-1:0] send_us_q);
            rtt_report_t r;
            if (due_reports.size() == 0) begin
                errors++;
                $display("%0t: result with no item outstanding, expected none, got status %0h",
                         $time, status);
                return;
            end
            r = due_reports.pop_front();
            compare_field("status", r.status, status);
            compare_field("ack_avg", r.ack_avg, ack_q);
            compare_field("send_avg", r.send_avg, send_q);
            compare_field("rtt_us", r.rtt_us, rtt_q);
            compare_field("matched_send_time", r.send_us, send_us_q);
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                i_opcode    = 1'b0;
    logic [SEQ_W-1:0]    i_seq_num   = '0;
    logic [TIME_W-1:0]   i_time_us   = '0;
    logic                i_cfg_we    = 1'b0;
    logic [WEIGHT_W-1:0] i_cfg_wdata = '0;
    logic                busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [AVG_W-1:0]    o_ack_avg;
    logic [AVG_W-1:0]    o_send_avg;
    logic [IV_W-1:0]     o_rtt_us;
    logic [TIME_W-1:0]   o_matched_send_time;

    rtt_ewma_board       board;
    bit [SEQ_W-1:0]      flow_seq;
    bit [SEQ_W-1:0]      flow_floor;
    bit [TIME_W-1:0]     flow_us;
    int unsigned         items_sent;
    int unsigned         settings_used;
    int unsigned         cycle_count;
    bit [WEIGHT_W-1:0]   phase_weight [PHASES] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'd0,
                                                   WEIGHT_RESET};
    int                  phase_sends  [PHASES] = '{40, 62, 45, 58, 50, 45};

    ack_rtt_ewma_tracker uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_opcode            (i_opcode),
        .i_seq_num           (i_seq_num),
        .i_time_us           (i_time_us),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_ack_avg           (o_ack_avg),
        .o_send_avg          (o_send_avg),
        .o_rtt_us            (o_rtt_us),
        .o_matched_send_time (o_matched_send_time)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Check every result strobe against the oldest owed report
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            board.check_report(o_status, o_ack_avg, o_send_avg, o_rtt_us,
                               o_matched_send_time);
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    // Present one item and hold it until the block takes it
    task automatic drive_item(input bit op, input bit [SEQ_W-1:0] seq,
                              input bit [TIME_W-1:0] t_us);
        @(negedge i_clk);
        start     <= 1'b1;
        i_opcode  <= op;
        i_seq_num <= seq;
        i_time_us <= t_us;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_event(op, seq, t_us);
        items_sent++;
    endtask

    // Drop start for a burst of idle cycles
    task automatic pause_items(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and wait until every owed report has come back
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.due_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_weight(input bit [WEIGHT_W-1:0] w);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.weight = w;
        settings_used++;
    endtask

    // Mostly an orderly send/ack flow, with resends, stale acks and noise mixed in
    task automatic random_item(input int send_pct);
        int              roll;
        bit              op;
        bit [SEQ_W-1:0]  seq;
        bit [TIME_W-1:0] t_us;
        roll     = $urandom_range(0, 99);
        flow_us += 64'($urandom_range(0, 3000));
        if ($urandom_range(0, 49) == 0)
            flow_us += {$urandom, $urandom} >> $urandom_range(12, 40);
        t_us = flow_us;
        if (roll < 6) begin
            op   = 1'($urandom_range(0, 1));
            seq  = $urandom;
            t_us = {$urandom, $urandom};
        end else if (roll < 12) begin
            op  = OP_SEND;
            seq = flow_seq - $urandom_range(1, 4);
        end else if (roll < 17) begin
            // seq-1 already purged; sometimes with the clock running back
            op  = OP_ACK;
            seq = flow_floor;
            if ($urandom_range(0, 1))
                t_us = flow_us - 64'($urandom_range(1, 5000));
        end else if (roll < 17 + send_pct || flow_floor >= flow_seq) begin
            op = OP_SEND;
            seq = flow_seq;
            flow_seq++;
        end else begin
            op  = OP_ACK;
            seq = flow_floor + $urandom_range(1, 3);
            if (seq > flow_seq)
                seq = flow_seq;
            flow_floor = seq;
        end
        drive_item(op, seq, t_us);
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // First ack, seq zero: nothing to match, nothing purged
        drive_item(OP_ACK, 32'd0, 64'd0);
        drive_item(OP_SEND, SEQ_TOP, 64'd100);
        drive_item(OP_SEND, SEQ_TOP, 64'd150);
        // seq zero ack wraps its lookup to the top seq
        drive_item(OP_ACK, 32'd0, 64'd300);
        // Fill the rest of the table, then overflow it
        for (int i = 0; i < DEPTH - 1; i++)
            drive_item(OP_SEND, 32'd10 + i, 64'd1000 + 10 * i);
        drive_item(OP_SEND, 32'd10 + DEPTH - 1, 64'd2000);
        // Ack time before the send time and before the last ack
        drive_item(OP_ACK, 32'd11, 64'd50);
        // Huge jump: the ack interval and the RTT saturate
        drive_item(OP_ACK, 32'd12, TIME_TOP);
        drive_item(OP_SEND, 32'd0, TIME_TOP);
        drive_item(OP_ACK, 32'd5, 64'h8000_0000_0000_0000);

        flow_us         = 64'h1_0000;
        phase_weight[4] = 16'($urandom_range(2, 65534));
        for (int p = 0; p < PHASES; p++) begin
            write_weight(phase_weight[p]);
            flow_seq   = $urandom_range(1, 32'h4000_0000);
            flow_floor = flow_seq;
            // flush leftovers of the previous phase
            drive_item(OP_ACK, SEQ_TOP, flow_us);
            repeat (PHASE_ITEMS) begin
                if (p < PHASES - 1 && p != 2 && $urandom_range(0, 5) == 0)
                    pause_items($urandom_range(1, 11));
                random_item(phase_sends[p]);
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Covered %0d items over %0d weight settings, weight extremes included",
                 items_sent, settings_used);
        $display("stored %0d, duplicate %0d, dropped full %0d, matched %0d, unmatched %0d",
                 board.tally[ST_STORED], board.tally[ST_DUPLICATE], board.tally[ST_FULL],
                 board.tally[ST_MATCHED], board.tally[ST_UNMATCHED]);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
